// ===== hdl/ts_pid_filter_table_defines.svh =====
// ----------------------------------------------------------------------------
// ts_pid_filter_table_defines
// assertion macros shared by the filter table checker
// ----------------------------------------------------------------------------
`ifndef TS_PID_FILTER_TABLE_DEFINES_SVH
`define TS_PID_FILTER_TABLE_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define TSPFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition must hold in the cycle after the trigger
`define TSPFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/tspft_pkg.sv =====
// ----------------------------------------------------------------------------
// tspft_pkg
// field widths, beat layout and command/status codes of the pid filter table
// ----------------------------------------------------------------------------
package tspft_pkg;

   // command beat fields
   localparam int CMD_W  = 3;
   localparam int CH_W   = 4;
   localparam int PID_W  = 13;
   localparam int QID_W  = 4;

   localparam int CMD_LSB  = 0;
   localparam int CH_LSB   = CMD_LSB + CMD_W;
   localparam int PID_LSB  = CH_LSB + CH_W;
   localparam int NPID_LSB = PID_LSB + PID_W;
   localparam int QID_LSB  = NPID_LSB + PID_W;
   localparam int REQ_BITS = QID_LSB + QID_W;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;

   // result beat fields
   localparam int STAT_W   = 2;
   localparam int IDX_W    = 5;
   localparam int RSP_BITS = STAT_W + IDX_W;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // table words
   localparam int PRIM_W = 32;
   localparam int SEC_W  = 19;

   // commands
   localparam logic [CMD_W-1:0] CMD_ADD       = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REPLACE   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DUPLICATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FLUSH     = 3'd4;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
   localparam logic [STAT_W-1:0] ST_SAME  = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADCH = 2'd3;

endpackage

// ===== hdl/ts_pid_filter_table.sv =====
// ----------------------------------------------------------------------------
// ts_pid_filter_table
// per-channel transport stream pid filter table with a sequential scanner
// ----------------------------------------------------------------------------
// The table holds CHANNELS x ENTRIES entries, each a primary word (valid,
// remap action, new pid, queue, pid) and a secondary word (valid, action,
// new pid, queue), kept in two single-port-write / single-port-read memories.
// Every command beat yields exactly one result beat. Add, delete, replace and
// duplicate walk the slots of one channel from slot 0 through one shared
// read-and-compare unit, one slot per cycle with a registered read, and stop
// at the first hit, which is written back in the same cycle it is found.
// Flush sweeps the channel one slot per cycle; channel codes from CHANNELS
// to 2 x CHANNELS - 1 flush only the secondary words of the matching channel.
// After reset the block clears both memories, one entry per cycle, and holds
// req_tready low until every entry is cleared.
// One command is in work at a time; a finished result sits in the output
// register while the next command beat is taken.
// ----------------------------------------------------------------------------
module ts_pid_filter_table #(
   parameter int ENTRIES  = 32,
   parameter int CHANNELS = 6
) (
   input  logic                       clock,
   input  logic                       reset,
   // command beat
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // command[2:0], channel[6:3], pid[19:7], new_pid[32:20], queue_id[36:33], zero pad
   input  logic [tspft_pkg::REQ_W-1:0] req_tdata,
   // result beat
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // status[1:0], entry_index[6:2], zero pad
   output logic [tspft_pkg::RSP_W-1:0] rsp_tdata
);

   import tspft_pkg::*;

   // table geometry
   localparam int TOTAL = CHANNELS * ENTRIES;
   localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int IW    = $clog2(TOTAL + 1);
   localparam int CHC_W = CH_W + 2;

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_FLUSH,
      S_RESP
   } state_type;

   // sequencer state
   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [CH_W-1:0]      ch_ff, ch_in;
   logic [PID_W-1:0]     pid_ff, pid_in;
   logic [PID_W-1:0]     npid_ff, npid_in;
   logic [QID_W-1:0]     qid_ff, qid_in;
   logic [AW-1:0]        base_ff, base_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]        init_ff, init_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [SW-1:0]        rd_slot_ff, rd_slot_in;
   logic                 flush_prim_ff, flush_prim_in;
   logic [STAT_W-1:0]    status_ff, status_in;
   logic [IDX_W-1:0]     index_ff, index_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_W-1:0]     rsp_tdata_ff, rsp_tdata_in;

   // memory ports
   logic [PRIM_W-1:0]    prim_mem [TOTAL];
   logic [SEC_W-1:0]     sec_mem [TOTAL];
   logic [PRIM_W-1:0]    prim_rd_ff;
   logic [SEC_W-1:0]     sec_rd_ff;
   logic                 prim_we, sec_we;
   logic [AW-1:0]        waddr, raddr;
   logic [PRIM_W-1:0]    prim_wdata;
   logic [SEC_W-1:0]     sec_wdata;

   // command beat fields
   logic [CMD_W-1:0]     req_cmd;
   logic [CH_W-1:0]      req_ch;
   logic [PID_W-1:0]     req_pid;
   logic [PID_W-1:0]     req_npid;
   logic [QID_W-1:0]     req_qid;

   // scan compare
   logic                 hit;
   logic                 last_slot;
   logic                 issue;

   assign req_cmd  = req_tdata[CMD_LSB +: CMD_W];
   assign req_ch   = req_tdata[CH_LSB +: CH_W];
   assign req_pid  = req_tdata[PID_LSB +: PID_W];
   assign req_npid = req_tdata[NPID_LSB +: PID_W];
   assign req_qid  = req_tdata[QID_LSB +: QID_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // shared compare unit: add looks for a free slot, the rest for a valid pid match
   always_comb begin
      if (cmd_ff == CMD_ADD) begin
         hit = rd_vld_ff && !prim_rd_ff[PRIM_W-1];
      end else begin
         hit = rd_vld_ff && prim_rd_ff[PRIM_W-1] && (prim_rd_ff[PID_W-1:0] == pid_ff);
      end
   end

   assign last_slot = rd_vld_ff && (rd_slot_ff == SW'(ENTRIES - 1));
   assign issue     = (state_ff == S_SCAN) && (cnt_ff < CW'(ENTRIES)) && !hit;
   assign raddr     = base_ff + AW'(cnt_ff[SW-1:0]);

   // write port control and write-back merge
   always_comb begin
      prim_we    = 1'b0;
      sec_we     = 1'b0;
      waddr      = base_ff + AW'(rd_slot_ff);
      prim_wdata = '0;
      sec_wdata  = '0;
      unique case (state_ff)
         S_INIT: begin
            prim_we = 1'b1;
            sec_we  = 1'b1;
            waddr   = init_ff[AW-1:0];
         end
         S_FLUSH: begin
            prim_we = flush_prim_ff;
            sec_we  = 1'b1;
            waddr   = base_ff + AW'(cnt_ff[SW-1:0]);
         end
         S_SCAN: begin
            if (hit) begin
               case (cmd_ff)
                  CMD_ADD: begin
                     prim_we    = 1'b1;
                     prim_wdata = {1'b1, prim_rd_ff[PRIM_W-2:PID_W+QID_W], ch_ff, pid_ff};
                  end
                  CMD_DELETE: begin
                     prim_we    = 1'b1;
                     prim_wdata = '0;
                  end
                  CMD_REPLACE: begin
                     prim_we    = 1'b1;
                     prim_wdata = {prim_rd_ff[PRIM_W-1], 1'b1, npid_ff,
                                   prim_rd_ff[PID_W+QID_W-1:0]};
                  end
                  default: begin
                     sec_we = 1'b1;
                     if (pid_ff != npid_ff) begin
                        sec_wdata = {1'b1, 1'b1, npid_ff, qid_ff};
                     end else begin
                        sec_wdata = {1'b1, sec_rd_ff[SEC_W-2:QID_W], qid_ff};
                     end
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // table memories, registered read
   always_ff @(posedge clock) begin
      if (prim_we) begin
         prim_mem[waddr] <= prim_wdata;
      end
      if (sec_we) begin
         sec_mem[waddr] <= sec_wdata;
      end
      prim_rd_ff <= prim_mem[raddr];
      sec_rd_ff  <= sec_mem[raddr];
   end

   // sequencer next state
   always_comb begin
      logic [31:0] slot_ext;

      slot_ext      = 32'(rd_slot_ff);
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      ch_in         = ch_ff;
      pid_in        = pid_ff;
      npid_in       = npid_ff;
      qid_in        = qid_ff;
      base_in       = base_ff;
      cnt_in        = cnt_ff;
      init_in       = init_ff;
      rd_vld_in     = issue;
      rd_slot_in    = issue ? cnt_ff[SW-1:0] : rd_slot_ff;
      flush_prim_in = flush_prim_ff;
      status_in     = status_ff;
      index_in      = index_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;

      unique case (state_ff)
         S_INIT: begin
            init_in = init_ff + IW'(1);
            if (init_ff == IW'(TOTAL - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = req_cmd;
               ch_in     = req_ch;
               pid_in    = req_pid;
               npid_in   = req_npid;
               qid_in    = req_qid;
               cnt_in    = '0;
               status_in = ST_OK;
               index_in  = '0;
               base_in   = AW'(req_ch * ENTRIES);
               if (req_cmd == CMD_FLUSH) begin
                  if (CHC_W'(req_ch) < CHC_W'(CHANNELS)) begin
                     // whole entries of the channel
                     flush_prim_in = 1'b1;
                     state_in      = S_FLUSH;
                  end else if (CHC_W'(req_ch) < CHC_W'(2 * CHANNELS)) begin
                     // secondary words only
                     flush_prim_in = 1'b0;
                     base_in       = AW'((CHC_W'(req_ch) - CHC_W'(CHANNELS)) * ENTRIES);
                     state_in      = S_FLUSH;
                  end else begin
                     status_in = ST_BADCH;
                     state_in  = S_RESP;
                  end
               end else if (req_cmd > CMD_FLUSH) begin
                  status_in = ST_MISS;
                  state_in  = S_RESP;
               end else if (CHC_W'(req_ch) >= CHC_W'(CHANNELS)) begin
                  status_in = ST_BADCH;
                  state_in  = S_RESP;
               end else if ((req_cmd == CMD_REPLACE) && (req_pid == req_npid)) begin
                  status_in = ST_SAME;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (hit) begin
               // first hit was written back this cycle
               status_in = ST_OK;
               index_in  = slot_ext[IDX_W-1:0];
               state_in  = S_RESP;
            end else if (last_slot) begin
               status_in = ST_MISS;
               index_in  = '0;
               state_in  = S_RESP;
            end
         end
         S_FLUSH: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(ENTRIES - 1)) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // load the output register once it is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = RSP_W'({index_ff, status_ff});
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // sequencer registers and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_ff       <= '0;
         cnt_ff        <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_ff       <= init_in;
         cnt_ff        <= cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff        <= cmd_in;
      ch_ff         <= ch_in;
      pid_ff        <= pid_in;
      npid_ff       <= npid_in;
      qid_ff        <= qid_in;
      base_ff       <= base_in;
      rd_slot_ff    <= rd_slot_in;
      flush_prim_ff <= flush_prim_in;
      status_ff     <= status_in;
      index_ff      <= index_in;
      rsp_tdata_ff  <= rsp_tdata_in;
   end

endmodule

// ===== hdl/tspft_checker.sv =====
// ----------------------------------------------------------------------------
// tspft_checker
// port-level checks of the pid filter table, bound to the top level
// ----------------------------------------------------------------------------
`include "ts_pid_filter_table_defines.svh"

module tspft_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   // command[2:0], channel[6:3], pid[19:7], new_pid[32:20], queue_id[36:33], zero pad
   input logic [tspft_pkg::REQ_W-1:0] req_tdata,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   // status[1:0], entry_index[6:2], zero pad
   input logic [tspft_pkg::RSP_W-1:0] rsp_tdata
);

   import tspft_pkg::*;

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pend_ff;
   logic [1:0] pend_in;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // commands taken but not yet answered
   always_comb begin
      pend_in = pend_ff + 2'(req_beat) - 2'(rsp_beat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `TSPFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")
   `TSPFT_ASSERT_NEXT(a_busy_after_cmd, clock, reset, req_beat, !req_tready, "command taken while a command is in work")
   `TSPFT_ASSERT_SAME(a_err_no_index, clock, reset, rsp_tvalid && (rsp_tdata[STAT_W-1:0] != ST_OK), rsp_tdata[STAT_W +: IDX_W] == '0, "failed command reports a slot")
   `TSPFT_ASSERT_SAME(a_rsp_has_cmd, clock, reset, rsp_beat, pend_ff != 2'd0, "result beat without a command")

endmodule

bind ts_pid_filter_table tspft_checker u_tspft_checker (.*);
